@@ sv/pdm_pkg.sv @@
`default_nettype none

package pdm_pkg;

  // field widths fixed by the item format
  localparam int DOC_W      = 10;
  localparam int OFFSET_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOC_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE = 2'd1;

  // request class decided at the front
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_SKIP,
    KIND_MAP
  } kind_e;

  // configuration seen by the search engine
  typedef struct packed {
    logic [DOC_W-1:0] doc_count;
    logic             merge_mode;
  } cfg_t;

  // head of the request queue
  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic  last;
  } head_t;

endpackage

`default_nettype wire

@@ sv/pdm_ram.sv @@
`default_nettype none

module pdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/pdm_front.sv @@
`default_nettype none

module pdm_front #(
  parameter int TABLE_DEPTH    = 1024,
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic                           command_i,
  input  wire logic [pdm_pkg::DOC_W-1:0]      entry_index_i,
  input  wire logic [POSITION_WIDTH-1:0]      position_i,
  input  wire logic                           last_in_list_i,
  output pdm_pkg::head_t                      head_o,
  output logic      [pdm_pkg::DOC_W-1:0]      head_index_o,
  output logic      [POSITION_WIDTH-1:0]      head_position_o,
  input  wire logic                           head_pop_i
);

  localparam int QD    = pdm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  pdm_pkg::kind_e                kind_q  [QD];
  logic [pdm_pkg::DOC_W-1:0]     index_q [QD];
  logic [POSITION_WIDTH-1:0]     pos_q   [QD];
  logic                          last_q  [QD];

  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  pdm_pkg::kind_e kind_in;
  logic           wr_en;
  logic           rd_en;

  // classify the incoming request
  always_comb begin
    if (command_i == pdm_pkg::CMD_MAP) begin
      kind_in = pdm_pkg::KIND_MAP;
    end else if (int'(entry_index_i) < TABLE_DEPTH) begin
      kind_in = pdm_pkg::KIND_LOAD;
    end else begin
      kind_in = pdm_pkg::KIND_SKIP;
    end
  end

  assign full_o = (cnt_q == CNT_W'(QD));
  assign wr_en  = push_i && !full_o;
  assign rd_en  = head_pop_i && (cnt_q != '0);

  // queue pointers and fill count
  always_comb begin
    wr_d  = wr_en ? wr_q + 1'b1 : wr_q;
    rd_d  = rd_en ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      kind_q[wr_q]  <= kind_in;
      index_q[wr_q] <= entry_index_i;
      pos_q[wr_q]   <= position_i;
      last_q[wr_q]  <= last_in_list_i;
    end
  end

  // head of queue toward the search engine
  always_comb begin
    head_o.valid    = (cnt_q != '0);
    head_o.kind     = kind_q[rd_q];
    head_o.last     = last_q[rd_q];
    head_index_o    = index_q[rd_q];
    head_position_o = pos_q[rd_q];
  end

endmodule

`default_nettype wire

@@ sv/pdm_back.sv @@
`default_nettype none

module pdm_back #(
  parameter int TABLE_DEPTH    = 1024,
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pdm_pkg::cfg_t                 cfg_i,
  input  wire pdm_pkg::head_t                head_i,
  input  wire logic [pdm_pkg::DOC_W-1:0]     head_index_i,
  input  wire logic [POSITION_WIDTH-1:0]     head_position_i,
  output logic                               head_pop_o,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output logic      [pdm_pkg::DOC_W-1:0]     doc_id_o,
  output logic      [pdm_pkg::OFFSET_W-1:0]  doc_offset_o,
  output logic                               out_of_range_o,
  output logic                               list_end_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = POSITION_WIDTH;
  localparam int DW = pdm_pkg::DOC_W;
  localparam int OW = pdm_pkg::OFFSET_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_GCHK = 3'd3;
  localparam logic [2:0] ST_BCHK = 3'd4;

  // what the pending table read is for
  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_LAST    = 3'd1;
  localparam logic [2:0] PH_CURSOR  = 3'd2;
  localparam logic [2:0] PH_GALLOP  = 3'd3;
  localparam logic [2:0] PH_BINARY  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [2:0]    phase_q, phase_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          last_q, last_d;
  logic [PW-1:0] t0_q, t0_d;
  logic [PW-1:0] lo_val_q, lo_val_d;
  logic [DW-1:0] lo_q, lo_d;
  logic [DW-1:0] hi_q, hi_d;
  logic [DW-1:0] step_q, step_d;
  logic [DW-1:0] addr_q, addr_d;
  logic [DW-1:0] cursor_q, cursor_d;
  logic [DW-1:0] last_doc_q, last_doc_d;
  logic          emitted_q, emitted_d;

  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] out_doc_q, out_doc_d;
  logic [OW-1:0] out_off_q, out_off_d;
  logic          out_oor_q, out_oor_d;
  logic          out_end_q, out_end_d;

  logic          ram_we;
  logic          ram_re;
  logic [DW-1:0] ram_raddr;
  logic [PW-1:0] rdata;

  logic [DW-1:0] n_docs;
  logic [DW-1:0] cur_clamp;
  logic          v_le_p;
  logic [DW:0]   sum;
  logic [DW:0]   dbl;
  logic [DW-1:0] diff;
  logic [DW-1:0] mid;
  logic [PW-1:0] offset;
  logic          can_emit;

  pdm_ram #(
    .WIDTH (PW),
    .DEPTH (TABLE_DEPTH)
  ) u_pdm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(head_index_i)),
    .wdata_i (head_position_i),
    .re_i    (ram_re),
    .raddr_i (AW'(ram_raddr)),
    .rdata_o (rdata)
  );

  // datapath helpers
  always_comb begin
    if (int'(cfg_i.doc_count) > TABLE_DEPTH - 1) begin
      n_docs = DW'(TABLE_DEPTH - 1);
    end else begin
      n_docs = cfg_i.doc_count;
    end
    cur_clamp = (cursor_q >= n_docs) ? n_docs - 1'b1 : cursor_q;
    v_le_p    = (rdata <= pos_q);
    sum       = {1'b0, lo_q} + {1'b0, step_q};
    dbl       = {step_q, 1'b0};
    diff      = hi_q - lo_q;
    mid       = lo_q + (diff >> 1);
    offset    = pos_q - lo_val_q;
    can_emit  = !out_valid_q || pop_i;
  end

  // search sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    pos_d      = pos_q;
    last_d     = last_q;
    t0_d       = t0_q;
    lo_val_d   = lo_val_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    step_d     = step_q;
    addr_d     = addr_q;
    cursor_d   = cursor_q;
    last_doc_d = last_doc_q;
    emitted_d  = emitted_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = addr_q;
    head_pop_o = 1'b0;

    out_valid_d = out_valid_q && !pop_i;
    out_doc_d   = out_doc_q;
    out_off_d   = out_off_q;
    out_oor_d   = out_oor_q;
    out_end_d   = out_end_q;

    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          case (head_i.kind)
            pdm_pkg::KIND_LOAD: begin
              ram_we     = 1'b1;
              head_pop_o = 1'b1;
            end
            pdm_pkg::KIND_MAP: begin
              if (n_docs == '0) begin
                // no documents: every position is out of range
                if (can_emit) begin
                  head_pop_o  = 1'b1;
                  out_valid_d = 1'b1;
                  out_doc_d   = '0;
                  out_off_d   = '0;
                  out_oor_d   = 1'b1;
                  out_end_d   = head_i.last;
                  if (head_i.last) begin
                    cursor_d  = '0;
                    emitted_d = 1'b0;
                  end
                end
              end else begin
                head_pop_o = 1'b1;
                pos_d      = head_position_i;
                last_d     = head_i.last;
                addr_d     = '0;
                phase_d    = PH_FIRST;
                state_d    = ST_READ;
              end
            end
            default: begin
              head_pop_o = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = addr_q;
        state_d   = ST_EVAL;
      end

      ST_EVAL: begin
        case (phase_q)
          PH_FIRST: begin
            if (!v_le_p) begin
              // before the first start
              if (can_emit) begin
                out_valid_d = 1'b1;
                out_doc_d   = '0;
                out_off_d   = '0;
                out_oor_d   = 1'b1;
                out_end_d   = last_q;
                if (last_q) begin
                  cursor_d  = '0;
                  emitted_d = 1'b0;
                end
                state_d = ST_IDLE;
              end
            end else begin
              t0_d    = rdata;
              addr_d  = n_docs;
              phase_d = PH_LAST;
              state_d = ST_READ;
            end
          end
          PH_LAST: begin
            if (v_le_p) begin
              // at or past the end boundary
              if (can_emit) begin
                out_valid_d = 1'b1;
                out_doc_d   = '0;
                out_off_d   = '0;
                out_oor_d   = 1'b1;
                out_end_d   = last_q;
                if (last_q) begin
                  cursor_d  = '0;
                  emitted_d = 1'b0;
                end
                state_d = ST_IDLE;
              end
            end else if (cur_clamp == '0) begin
              lo_d     = '0;
              lo_val_d = t0_q;
              step_d   = DW'(1);
              state_d  = ST_GCHK;
            end else begin
              addr_d  = cur_clamp;
              phase_d = PH_CURSOR;
              state_d = ST_READ;
            end
          end
          PH_CURSOR: begin
            // a position behind the cursor restarts from document zero
            if (v_le_p) begin
              lo_d     = addr_q;
              lo_val_d = rdata;
            end else begin
              lo_d     = '0;
              lo_val_d = t0_q;
            end
            step_d  = DW'(1);
            state_d = ST_GCHK;
          end
          PH_GALLOP: begin
            if (v_le_p) begin
              lo_d     = addr_q;
              lo_val_d = rdata;
              step_d   = (dbl > {1'b0, n_docs}) ? n_docs : dbl[DW-1:0];
              state_d  = ST_GCHK;
            end else begin
              hi_d    = addr_q;
              state_d = ST_BCHK;
            end
          end
          PH_BINARY: begin
            if (v_le_p) begin
              lo_d     = addr_q;
              lo_val_d = rdata;
            end else begin
              hi_d = addr_q;
            end
            state_d = ST_BCHK;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_GCHK: begin
        // next galloping probe, or close the bracket
        if (sum < {1'b0, n_docs}) begin
          ram_re    = 1'b1;
          ram_raddr = sum[DW-1:0];
          addr_d    = sum[DW-1:0];
          phase_d   = PH_GALLOP;
          state_d   = ST_EVAL;
        end else begin
          hi_d    = (sum > {1'b0, n_docs}) ? n_docs : sum[DW-1:0];
          state_d = ST_BCHK;
        end
      end

      ST_BCHK: begin
        if (diff > DW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = mid;
          addr_d    = mid;
          phase_d   = PH_BINARY;
          state_d   = ST_EVAL;
        end else if (can_emit) begin
          // document found
          cursor_d = last_q ? '0 : lo_q;
          if (!cfg_i.merge_mode) begin
            out_valid_d = 1'b1;
            out_doc_d   = lo_q;
            out_off_d   = OW'(offset);
            out_oor_d   = 1'b0;
            out_end_d   = last_q;
          end else if (!emitted_q || (last_doc_q != lo_q)) begin
            out_valid_d = 1'b1;
            out_doc_d   = lo_q;
            out_off_d   = '0;
            out_oor_d   = 1'b0;
            out_end_d   = last_q;
            last_doc_d  = lo_q;
            emitted_d   = 1'b1;
          end
          if (last_q) begin
            emitted_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FIRST;
      cursor_q    <= '0;
      last_doc_q  <= '0;
      emitted_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cursor_q    <= cursor_d;
      last_doc_q  <= last_doc_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    last_q    <= last_d;
    t0_q      <= t0_d;
    lo_val_q  <= lo_val_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    step_q    <= step_d;
    addr_q    <= addr_d;
    out_doc_q <= out_doc_d;
    out_off_q <= out_off_d;
    out_oor_q <= out_oor_d;
    out_end_q <= out_end_d;
  end

  assign empty_o        = !out_valid_q;
  assign doc_id_o       = out_doc_q;
  assign doc_offset_o   = out_off_q;
  assign out_of_range_o = out_oor_q;
  assign list_end_o     = out_end_q;

endmodule

`default_nettype wire

@@ sv/position_to_document_mapper.sv @@
// Flow: a request is registered in the front queue; a load is then written to the table
// from the head of the queue, and a map runs a search of boundary-table reads, each issued
// and then evaluated, bounded by the single table read port.
// Throughput: one load per cycle while no map is searching; one map per search time,
// the front queue and the result register let input and output stall on their own.
// Reset: clears cursor, merge state, queue and result register; table undefined until loaded.
`default_nettype none

module position_to_document_mapper #(
  parameter int TABLE_DEPTH    = 1024,
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic                             command_i,
  input  wire logic [pdm_pkg::DOC_W-1:0]        entry_index_i,
  input  wire logic [POSITION_WIDTH-1:0]        position_i,
  input  wire logic                             last_in_list_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic      [pdm_pkg::DOC_W-1:0]        doc_id_o,
  output logic      [pdm_pkg::OFFSET_W-1:0]     doc_offset_o,
  output logic                                  out_of_range_o,
  output logic                                  list_end_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pdm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pdm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [pdm_pkg::DOC_W-1:0] doc_count_q;
  logic                      merge_mode_q;
  pdm_pkg::cfg_t             cfg;
  pdm_pkg::head_t            head;
  logic [pdm_pkg::DOC_W-1:0] head_index;
  logic [POSITION_WIDTH-1:0] head_position;
  logic                      head_pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_count_q  <= pdm_pkg::DOC_W'(1);
      merge_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pdm_pkg::REG_DOC_COUNT: begin
          doc_count_q <= cfg_data_i[pdm_pkg::DOC_W-1:0];
        end
        pdm_pkg::REG_MERGE_MODE: begin
          merge_mode_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.doc_count  = doc_count_q;
    cfg.merge_mode = merge_mode_q;
  end

  pdm_front #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_pdm_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .position_i      (position_i),
    .last_in_list_i  (last_in_list_i),
    .head_o          (head),
    .head_index_o    (head_index),
    .head_position_o (head_position),
    .head_pop_i      (head_pop)
  );

  pdm_back #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_pdm_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .head_i          (head),
    .head_index_i    (head_index),
    .head_position_i (head_position),
    .head_pop_o      (head_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .doc_id_o        (doc_id_o),
    .doc_offset_o    (doc_offset_o),
    .out_of_range_o  (out_of_range_o),
    .list_end_o      (list_end_o)
  );

endmodule

`default_nettype wire

@@ sv/pdm_checker.sv @@
`default_nettype none

module pdm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [pdm_pkg::DOC_W-1:0]     doc_id_o,
  input wire logic [pdm_pkg::OFFSET_W-1:0]  doc_offset_o,
  input wire logic                          out_of_range_o,
  input wire logic                          list_end_o
);

  // no result is offered while reset is held
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result offered during reset");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(doc_id_o) && $stable(doc_offset_o)
                          && $stable(out_of_range_o) && $stable(list_end_o)))
    else $error("waiting result changed before pop");

  // out-of-range results carry zero document and offset
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_of_range_o) |-> (doc_id_o == '0 && doc_offset_o == '0))
    else $error("out-of-range result with nonzero fields");

  // a found document is always below the largest document count
  a_doc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_of_range_o) |-> (doc_id_o != '1))
    else $error("document id beyond table");

endmodule

bind position_to_document_mapper pdm_checker u_pdm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .doc_id_o       (doc_id_o),
  .doc_offset_o   (doc_offset_o),
  .out_of_range_o (out_of_range_o),
  .list_end_o     (list_end_o)
);

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int DOC_W         = pdm_pkg::DOC_W;
  localparam int OFFSET_W      = pdm_pkg::OFFSET_W;
  localparam int CFG_IDX_W     = pdm_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = pdm_pkg::CFG_DATA_W;
  localparam int POS_W         = 32;
  localparam int TBL_DEPTH     = 1024;
  localparam int LARGE_DOCS    = 300;
  localparam int SETTLE_CYCLES = 256;
  localparam int STALL_LIMIT   = 4000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [DOC_W-1:0]    doc_id;
    logic [OFFSET_W-1:0] doc_offset;
    logic                out_of_range;
    logic                list_end;
  } doc_hit_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b1;
  logic                  push           = 1'b0;
  logic                  full;
  logic                  command_i      = pdm_pkg::CMD_LOAD;
  logic [DOC_W-1:0]      entry_index_i  = '0;
  logic [POS_W-1:0]      position_i     = '0;
  logic                  last_in_list_i = 1'b0;
  logic                  empty;
  logic                  pop            = 1'b0;
  logic [DOC_W-1:0]      doc_id_o;
  logic [OFFSET_W-1:0]   doc_offset_o;
  logic                  out_of_range_o;
  logic                  list_end_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  // shadow copy of the mapper state
  logic [POS_W-1:0] bound_tbl [TBL_DEPTH];
  logic [DOC_W-1:0] cfg_doc_count = 10'd1;
  logic             cfg_merge     = 1'b0;
  int unsigned      cursor_doc    = 0;
  logic [DOC_W-1:0] last_doc      = '0;
  logic             doc_emitted   = 1'b0;

  doc_hit_t    pending_hits [$];
  doc_hit_t    seen_hit;
  doc_hit_t    want_hit;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned maps_sent      = 0;
  int unsigned loads_sent     = 0;
  int unsigned hits_checked   = 0;
  int unsigned fail_count     = 0;

  position_to_document_mapper i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .entry_index_i  (entry_index_i),
    .position_i     (position_i),
    .last_in_list_i (last_in_list_i),
    .empty          (empty),
    .pop            (pop),
    .doc_id_o       (doc_id_o),
    .doc_offset_o   (doc_offset_o),
    .out_of_range_o (out_of_range_o),
    .list_end_o     (list_end_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // shadow table entry k
  function automatic logic [POS_W-1:0] tbl_at(input int unsigned k);
    return bound_tbl[DOC_W'(k)];
  endfunction

  // last document in [start, n-1] whose start is not above pos
  function automatic int unsigned gallop_to_doc(input int unsigned start, input int unsigned n,
                                                input logic [POS_W-1:0] pos);
    int unsigned lo, step, hi, mid;
    lo = start;
    step = 1;
    while (lo + step < n && tbl_at(lo + step) <= pos) begin
      lo += step;
      step = step * 2;
      if (step > n) step = n;
    end
    hi = lo + step;
    if (hi > n) hi = n;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_at(mid) <= pos) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // expected result of one request, updates the shadow state
  function automatic bit predict_mapping(input logic cmd, input logic [DOC_W-1:0] idx,
                                         input logic [POS_W-1:0] pos, input logic last,
                                         output doc_hit_t hit);
    int unsigned n, c, d;
    bit emit;
    hit = '0;
    hit.list_end = last;
    emit = 1'b0;
    if (cmd == pdm_pkg::CMD_LOAD) begin
      bound_tbl[idx] = pos;
      return 1'b0;
    end
    n = int'(cfg_doc_count);
    if (n == 0 || pos < tbl_at(0) || pos >= tbl_at(n)) begin
      hit.out_of_range = 1'b1;
      emit = 1'b1;
    end else begin
      // cursor clamped to the documents in use, restart when behind it
      c = (cursor_doc >= n) ? n - 1 : cursor_doc;
      if (tbl_at(c) > pos) c = 0;
      d = gallop_to_doc(c, n, pos);
      cursor_doc = d;
      hit.doc_id = DOC_W'(d);
      if (!cfg_merge) begin
        hit.doc_offset = pos - tbl_at(d);
        emit = 1'b1;
      end else if (!doc_emitted || last_doc != DOC_W'(d)) begin
        last_doc = DOC_W'(d);
        doc_emitted = 1'b1;
        emit = 1'b1;
      end
    end
    if (last) begin
      cursor_doc = 0;
      doc_emitted = 1'b0;
    end
    return emit;
  endfunction

  // random position inside document d, its start now and then
  function automatic logic [POS_W-1:0] pick_inside(input int unsigned d);
    logic [POS_W-1:0] lo, span;
    lo = tbl_at(d);
    span = tbl_at(d + 1) - lo;
    if (tbl_at(d + 1) <= lo || $urandom_range(0, 3) == 0) return lo;
    return lo + $urandom % span;
  endfunction

  // random position below the first start or at or past the end boundary
  function automatic logic [POS_W-1:0] pick_outside(input int unsigned n);
    longint unsigned above;
    above = 64'h1_0000_0000 - tbl_at(n);
    if (tbl_at(0) != 0 && $urandom_range(0, 1)) begin
      if ($urandom_range(0, 3) == 0) return tbl_at(0) - 1;
      return $urandom % tbl_at(0);
    end
    if ($urandom_range(0, 3) == 0) return tbl_at(n);
    return tbl_at(n) + POS_W'($urandom % above);
  endfunction

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // one request through push / full, predicted once accepted
  task automatic send_request(input logic cmd, input logic [DOC_W-1:0] idx,
                              input logic [POS_W-1:0] pos, input logic last);
    doc_hit_t hit;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    entry_index_i <= idx;
    position_i <= pos;
    last_in_list_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (predict_mapping(cmd, idx, pos, last, hit)) pending_hits.push_back(hit);
    items_sent++;
    if (cmd == pdm_pkg::CMD_LOAD) loads_sent++;
    else maps_sent++;
  endtask

  task automatic map_position(input logic [POS_W-1:0] pos, input logic last);
    send_request(pdm_pkg::CMD_MAP, DOC_W'($urandom), pos, last);
  endtask

  // wait for every expected result, then let trailing requests settle
  task automatic drain_pipeline();
    push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    drain_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (index == pdm_pkg::REG_DOC_COUNT) cfg_doc_count = value[DOC_W-1:0];
    else if (index == pdm_pkg::REG_MERGE_MODE) cfg_merge = value[0];
  endtask

  // ascending boundaries 0..top, some documents left empty
  task automatic load_table(input int unsigned top, input logic [POS_W-1:0] first,
                            input int unsigned max_gap);
    longint unsigned start;
    start = first;
    for (int unsigned i = 0; i <= top; i++) begin
      if (i != 0 && $urandom_range(0, 9) != 0) start += $urandom_range(1, max_gap);
      if (start > 64'hFFFF_FFFF) start = 64'hFFFF_FFFF;
      send_request(pdm_pkg::CMD_LOAD, DOC_W'(i), POS_W'(start), 1'($urandom_range(0, 1)));
    end
  endtask

  // sorted lists with random content, plus stray and out of order requests
  task automatic run_lists(input int unsigned count);
    int unsigned n, goal, len, base, d, r, idx, near;
    logic [POS_W-1:0] list_pos [$];
    n = int'(cfg_doc_count);
    goal = items_sent + count;
    base = 0;
    while (items_sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        len = $urandom_range(1, 12);
        base = $urandom_range(0, n - 1);
        list_pos.delete();
        for (int unsigned k = 0; k < len; k++) begin
          near = $urandom_range(0, 2);
          if ($urandom_range(0, 1)) d = $urandom_range(0, n - 1);
          else d = (base + near < n) ? base + near : n - 1;
          list_pos.push_back(pick_inside(d));
        end
        list_pos.sort();
        for (int unsigned k = 0; k < len; k++) begin
          map_position(list_pos[k], k == len - 1 && $urandom_range(0, 99) < 85);
        end
      end else if (r < 85) begin
        map_position(pick_outside(n), 1'($urandom_range(0, 1)));
      end else if (r < 93) begin
        // usually behind the cursor of the list just sent
        map_position(pick_inside($urandom_range(0, base)), 1'($urandom_range(0, 1)));
      end else begin
        idx = $urandom_range(0, n);
        if ($urandom_range(0, 3) == 0) begin
          send_request(pdm_pkg::CMD_LOAD, DOC_W'(idx), POS_W'($urandom),
                       1'($urandom_range(0, 1)));
        end else begin
          send_request(pdm_pkg::CMD_LOAD, DOC_W'(idx), tbl_at(idx),
                       1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic test_directed_cases();
    set_idling(0, 0);
    // a load marked as list end leaves the cursor alone
    send_request(pdm_pkg::CMD_LOAD, 10'd0, 32'd100, 1'b0);
    send_request(pdm_pkg::CMD_LOAD, 10'd1, 32'd200, 1'b1);
    send_request(pdm_pkg::CMD_LOAD, 10'd2, 32'd200, 1'b0);
    send_request(pdm_pkg::CMD_LOAD, 10'd3, 32'd350, 1'b0);
    send_request(pdm_pkg::CMD_LOAD, 10'd4, 32'd1000, 1'b0);
    write_register(pdm_pkg::REG_DOC_COUNT, 10'd4);
    write_register(pdm_pkg::REG_MERGE_MODE, 10'd0);
    // annotate: below first start, exact starts, empty document, behind cursor, past end
    map_position(32'd99, 1'b0);
    map_position(32'd100, 1'b0);
    map_position(32'd199, 1'b0);
    map_position(32'd200, 1'b0);
    map_position(32'd360, 1'b0);
    map_position(32'd120, 1'b0);
    map_position(32'd999, 1'b0);
    map_position(32'd1000, 1'b0);
    map_position(32'hFFFF_FFFF, 1'b1);
    // merge: duplicates dropped, also on list end, and out of range keeps merge state
    write_register(pdm_pkg::REG_MERGE_MODE, 10'd1);
    map_position(32'd100, 1'b0);
    map_position(32'd150, 1'b0);
    map_position(32'd210, 1'b0);
    map_position(32'd220, 1'b1);
    map_position(32'd150, 1'b0);
    map_position(32'd99, 1'b0);
    map_position(32'd160, 1'b1);
    // cursor left beyond the documents after shrinking the count
    write_register(pdm_pkg::REG_MERGE_MODE, 10'd0);
    map_position(32'd999, 1'b0);
    write_register(pdm_pkg::REG_DOC_COUNT, 10'd3);
    map_position(32'd300, 1'b1);
    // no documents at all
    write_register(pdm_pkg::REG_DOC_COUNT, 10'd0);
    map_position(32'd150, 1'b1);
    write_register(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_register(REG_SPARE_B, CFG_DATA_W'($urandom));
    // one document spanning the whole position range
    write_register(pdm_pkg::REG_DOC_COUNT, 10'd1);
    send_request(pdm_pkg::CMD_LOAD, 10'd0, 32'd0, 1'b0);
    send_request(pdm_pkg::CMD_LOAD, 10'd1, 32'hFFFF_FFFF, 1'b0);
    map_position(32'd0, 1'b0);
    map_position(32'hFFFF_FFFE, 1'b0);
    map_position(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_small_tables();
    int unsigned docs;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(52, 0);
        2: set_idling(0, 52);
        default: set_idling(11, 11);
      endcase
      docs = $urandom_range(1, 48);
      load_table(docs, $urandom_range(1, 5000), $urandom_range(1, 2000));
      write_register(pdm_pkg::REG_DOC_COUNT, CFG_DATA_W'(docs));
      write_register(pdm_pkg::REG_MERGE_MODE, CFG_DATA_W'(phase % 2));
      run_lists(60);
      write_register(pdm_pkg::REG_MERGE_MODE, CFG_DATA_W'((phase + 1) % 2));
      run_lists(30);
    end
  endtask

  task automatic test_large_table();
    set_idling(0, 0);
    load_table(LARGE_DOCS, $urandom_range(1, 1000), 12000000);
    write_register(pdm_pkg::REG_DOC_COUNT, CFG_DATA_W'(LARGE_DOCS));
    write_register(pdm_pkg::REG_MERGE_MODE, 10'd0);
    set_idling(11, 11);
    run_lists(90);
    write_register(pdm_pkg::REG_MERGE_MODE, 10'd1);
    run_lists(50);
    // shrink the count with the cursor possibly still deep in the table
    set_idling(52, 0);
    write_register(pdm_pkg::REG_DOC_COUNT, CFG_DATA_W'($urandom_range(2, 40)));
    write_register(pdm_pkg::REG_MERGE_MODE, 10'd0);
    run_lists(30);
    set_idling(0, 52);
    write_register(pdm_pkg::REG_DOC_COUNT, 10'd1);
    run_lists(20);
  endtask

  // result check and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      seen_hit = {doc_id_o, doc_offset_o, out_of_range_o, list_end_o};
      if (pending_hits.size() == 0) begin
        $error("result with no request pending: doc_id %0d", seen_hit.doc_id);
        fail_count++;
      end else begin
        want_hit = pending_hits.pop_front();
        hits_checked++;
        if (seen_hit.doc_id !== want_hit.doc_id) begin
          $error("doc_id: expected %0d, got %0d", want_hit.doc_id, seen_hit.doc_id);
          fail_count++;
        end
        if (seen_hit.doc_offset !== want_hit.doc_offset) begin
          $error("doc_offset: expected %0h, got %0h", want_hit.doc_offset, seen_hit.doc_offset);
          fail_count++;
        end
        if (seen_hit.out_of_range !== want_hit.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", want_hit.out_of_range,
                 seen_hit.out_of_range);
          fail_count++;
        end
        if (seen_hit.list_end !== want_hit.list_end) begin
          $error("list_end: expected %0b, got %0b", want_hit.list_end, seen_hit.list_end);
          fail_count++;
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog on cycles where no request moves
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
    $display("** position_to_document_mapper: FAILED **");
    $finish;
  end

  // reset and test sequence
  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_small_tables();
    test_large_table();
    drain_pipeline();
    $display("sent %0d requests: %0d table loads, %0d occurrence lookups",
             items_sent, loads_sent, maps_sent);
    $display("checked %0d results in annotate and merge mode, 0 to %0d documents, %0d errors",
             hits_checked, LARGE_DOCS, fail_count);
    if (fail_count == 0) begin
      $display("** position_to_document_mapper: PASSED **");
    end else begin
      $display("** position_to_document_mapper: FAILED **");
    end
    $finish;
  end

endmodule
